[hdl/isa_pkg.sv]
// Shared widths, defaults and register indexes of the interval sample averager.
package isa_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned COUNT_BITS_DEF  = 10;

  localparam int unsigned SAMPLE_IVL_BITS = 16;
  localparam int unsigned SEND_IVL_BITS   = 20;
  localparam int unsigned CFG_INDEX_BITS  = 8;
  localparam int unsigned CFG_DATA_BITS   = 32;

  localparam logic [SAMPLE_IVL_BITS-1:0] SAMPLE_IVL_RESET = SAMPLE_IVL_BITS'(5000);
  localparam logic [SEND_IVL_BITS-1:0]   SEND_IVL_RESET   = SEND_IVL_BITS'(120000);

  localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_INTERVAL = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_SEND_INTERVAL   = CFG_INDEX_BITS'(1);

endpackage

[hdl/isa_if.sv]
// Handshake channel interfaces for the interval sample averager.
interface isa_in_if #(
  parameter int unsigned SAMPLE_BITS = isa_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_value;
  logic                   restart_window;

  modport source (output valid, sample_value, restart_window, input ready);
  modport sink   (input valid, sample_value, restart_window, output ready);
endinterface

interface isa_out_if #(
  parameter int unsigned SAMPLE_BITS = isa_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = isa_pkg::COUNT_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] average_value;
  logic [COUNT_BITS-1:0]  samples_averaged;

  modport source (output valid, average_value, samples_averaged, input ready);
  modport sink   (input valid, average_value, samples_averaged, output ready);
endinterface

interface isa_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [isa_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [isa_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/interval_sample_averager_core.sv]
// Interval sample averager: tick timers, sample accumulator and bit-serial mean divider.
// Flow: a request with no average due completes in its accept cycle; a request that makes an
// average due starts the divider, whose quotient is loaded into the output register after its steps.
// Rate: one request per cycle while no average is due; a request that makes one due blocks new
// requests until the divider ends and the output is loaded, longer while it waits for out_chan.ready.
// Reset (rst_n low, synchronous): timers, sum and count clear, output empties, intervals 5000/120000.
module interval_sample_averager_core #(
  parameter int unsigned SAMPLE_BITS = isa_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = isa_pkg::COUNT_BITS_DEF
) (
  input logic            clk,
  input logic            rst_n,
  isa_in_if.sink         in_chan,
  isa_out_if.source      out_chan,
  isa_cfg_if.sink        cfg_chan
);

  localparam int unsigned SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
  localparam int unsigned STEP_BITS = $clog2(SUM_BITS + 1);
  localparam int unsigned SS_BITS   = isa_pkg::SAMPLE_IVL_BITS;
  localparam int unsigned SD_BITS   = isa_pkg::SEND_IVL_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [SS_BITS-1:0]    sample_ivl_r;
  logic [SD_BITS-1:0]    send_ivl_r;
  logic [SS_BITS-1:0]    since_sample_r, since_sample_nxt;
  logic [SD_BITS-1:0]    since_send_r, since_send_nxt;
  logic [SUM_BITS-1:0]   sum_r, sum_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;

  // Divider: dividend/quotient shift register, partial remainder and divisor.
  logic [SUM_BITS-1:0]   dq_r, dq_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [COUNT_BITS-1:0] divisor_r, divisor_nxt;
  logic [STEP_BITS-1:0]  step_r, step_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_avg_r, out_avg_nxt;
  logic [COUNT_BITS-1:0]  out_cnt_r, out_cnt_nxt;

  logic                   in_fire;
  logic [SS_BITS-1:0]     ss_inc;
  logic [SD_BITS-1:0]     sd_base, sd_inc;
  logic [SUM_BITS-1:0]    sum_base, sum_upd;
  logic [COUNT_BITS-1:0]  cnt_base, cnt_upd;
  logic                   take, emit;
  logic [COUNT_BITS:0]    trial, diff;

  assign in_chan.ready           = (state_r == ST_IDLE);
  assign in_fire                 = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready          = 1'b1;
  assign out_chan.valid          = out_valid_r;
  assign out_chan.average_value  = out_avg_r;
  assign out_chan.samples_averaged = out_cnt_r;

  // Per-tick bookkeeping, restart clear applied first.
  always_comb begin
    sd_base  = in_chan.restart_window ? '0 : since_send_r;
    sum_base = in_chan.restart_window ? '0 : sum_r;
    cnt_base = in_chan.restart_window ? '0 : count_r;
    ss_inc   = (since_sample_r == '1) ? since_sample_r : since_sample_r + SS_BITS'(1);
    sd_inc   = (sd_base == '1) ? sd_base : sd_base + SD_BITS'(1);
    take     = (ss_inc >= sample_ivl_r);
    sum_upd  = sum_base;
    cnt_upd  = cnt_base;
    if (take && (cnt_base != '1)) begin
      sum_upd = sum_base + SUM_BITS'(in_chan.sample_value);
      cnt_upd = cnt_base + COUNT_BITS'(1);
    end
    emit = (sd_inc >= send_ivl_r) && (cnt_upd != '0);
  end

  // One restoring division step per cycle.
  always_comb begin
    trial = {rem_r, dq_r[SUM_BITS-1]};
    diff  = trial - {1'b0, divisor_r};
  end

  always_comb begin
    state_nxt        = state_r;
    since_sample_nxt = since_sample_r;
    since_send_nxt   = since_send_r;
    sum_nxt          = sum_r;
    count_nxt        = count_r;
    dq_nxt           = dq_r;
    rem_nxt          = rem_r;
    divisor_nxt      = divisor_r;
    step_nxt         = step_r;
    out_valid_nxt    = out_valid_r;
    out_avg_nxt      = out_avg_r;
    out_cnt_nxt      = out_cnt_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          since_sample_nxt = take ? '0 : ss_inc;
          if (emit) begin
            since_send_nxt = '0;
            sum_nxt        = '0;
            count_nxt      = '0;
            dq_nxt         = sum_upd;
            rem_nxt        = '0;
            divisor_nxt    = cnt_upd;
            step_nxt       = STEP_BITS'(SUM_BITS);
            state_nxt      = ST_DIV;
          end else begin
            since_send_nxt = sd_inc;
            sum_nxt        = sum_upd;
            count_nxt      = cnt_upd;
          end
        end
      end
      ST_DIV: begin
        if (!diff[COUNT_BITS]) begin
          rem_nxt = diff[COUNT_BITS-1:0];
          dq_nxt  = {dq_r[SUM_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = trial[COUNT_BITS-1:0];
          dq_nxt  = {dq_r[SUM_BITS-2:0], 1'b0};
        end
        step_nxt = step_r - STEP_BITS'(1);
        if (step_r == STEP_BITS'(1)) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // Wait until the output register is free or being drained this cycle.
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = dq_r[SAMPLE_BITS-1:0];
          out_cnt_nxt   = divisor_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      sample_ivl_r   <= isa_pkg::SAMPLE_IVL_RESET;
      send_ivl_r     <= isa_pkg::SEND_IVL_RESET;
      since_sample_r <= '0;
      since_send_r   <= '0;
      sum_r          <= '0;
      count_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      since_sample_r <= since_sample_nxt;
      since_send_r   <= since_send_nxt;
      sum_r          <= sum_nxt;
      count_r        <= count_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_chan.valid) begin
        case (cfg_chan.index)
          isa_pkg::REG_SAMPLE_INTERVAL: sample_ivl_r <= cfg_chan.data[SS_BITS-1:0];
          isa_pkg::REG_SEND_INTERVAL:   send_ivl_r   <= cfg_chan.data[SD_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    dq_r      <= dq_nxt;
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
    step_r    <= step_nxt;
    out_avg_r <= out_avg_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

endmodule

[verif/tb_interval_sample_averager_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the interval sample averager: directed table, a long window, then random phases.
module tb_interval_sample_averager_core;

  localparam int unsigned SB = isa_pkg::SAMPLE_BITS_DEF;
  localparam int unsigned CB = isa_pkg::COUNT_BITS_DEF;
  localparam int unsigned SUMB = SB + CB;
  localparam int unsigned SIB = isa_pkg::SAMPLE_IVL_BITS;
  localparam int unsigned SDB = isa_pkg::SEND_IVL_BITS;
  localparam int unsigned IXB = isa_pkg::CFG_INDEX_BITS;
  localparam int unsigned DB = isa_pkg::CFG_DATA_BITS;
  localparam int unsigned SI_HI = DB - SIB;
  localparam int unsigned SD_HI = DB - SDB;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 30;

  typedef struct packed {
    logic [SB-1:0] average_value;
    logic [CB-1:0] samples_averaged;
  } avg_result_t;

  typedef enum logic { ROW_CFG, ROW_TICK } row_kind_t;
  typedef enum logic [1:0] { CHK_MODEL, CHK_NONE, CHK_GIVEN } row_check_t;

  typedef struct {
    row_kind_t      kind;
    logic [IXB-1:0] index;
    logic [DB-1:0]  data;
    logic [SB-1:0]  sample;
    bit             restart;
    row_check_t     chk;
    avg_result_t    given;
  } plan_row_t;

  logic clk;
  logic rst_n;

  isa_in_if  #(.SAMPLE_BITS(SB))                  in_bus ();
  isa_out_if #(.SAMPLE_BITS(SB), .COUNT_BITS(CB)) out_bus ();
  isa_cfg_if                                      cfg_bus ();

  interval_sample_averager_core #(.SAMPLE_BITS(SB), .COUNT_BITS(CB)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  // Mirror of the averaging state.
  logic [SIB-1:0]  sample_ivl;
  logic [SDB-1:0]  send_ivl;
  logic [SIB-1:0]  ticks_since_sample;
  logic [SDB-1:0]  ticks_since_send;
  logic [SUMB-1:0] window_sum;
  logic [CB-1:0]   window_count;

  avg_result_t pending_averages[$];
  plan_row_t   plan[$];
  int unsigned mismatches;
  int unsigned averages_seen;
  int unsigned cycles;
  int unsigned stall_left;
  bit          steady;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic plan_row_t cfg_row(logic [IXB-1:0] idx, logic [DB-1:0] d);
    plan_row_t r;
    r = '{kind: ROW_CFG, index: idx, data: d, sample: '0, restart: 1'b0,
          chk: CHK_NONE, given: '0};
    return r;
  endfunction

  function automatic plan_row_t tick_row(logic [SB-1:0] s, bit rs, row_check_t c,
                                         logic [SB-1:0] a, logic [CB-1:0] n);
    plan_row_t r;
    r = '{kind: ROW_TICK, index: '0, data: '0, sample: s, restart: rs,
          chk: c, given: '0};
    r.given.average_value = a;
    r.given.samples_averaged = n;
    return r;
  endfunction

  function automatic void apply_reg(logic [IXB-1:0] idx, logic [DB-1:0] d);
    if (idx == isa_pkg::REG_SAMPLE_INTERVAL) sample_ivl = d[SIB-1:0];
    else if (idx == isa_pkg::REG_SEND_INTERVAL) send_ivl = d[SDB-1:0];
  endfunction

  // One tick: restart clear, timers advance, sample test, then send test.
  function automatic void advance_window(logic [SB-1:0] smp, bit restart,
                                         output bit emit, output avg_result_t res);
    emit = 1'b0;
    res = '0;
    if (restart) begin
      window_sum = '0;
      window_count = '0;
      ticks_since_send = '0;
    end
    if (ticks_since_sample != '1) ticks_since_sample = ticks_since_sample + SIB'(1);
    if (ticks_since_send != '1) ticks_since_send = ticks_since_send + SDB'(1);
    if (ticks_since_sample >= sample_ivl) begin
      ticks_since_sample = '0;
      // A full count drops the sample but the sample timer still restarts.
      if (window_count != '1) begin
        window_sum = window_sum + SUMB'(smp);
        window_count = window_count + CB'(1);
      end
    end
    if (ticks_since_send >= send_ivl && window_count != '0) begin
      res.average_value = SB'(window_sum / SUMB'(window_count));
      res.samples_averaged = window_count;
      emit = 1'b1;
      ticks_since_send = '0;
      window_sum = '0;
      window_count = '0;
    end
  endfunction

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  // Present one tick request after an optional gap and wait until it is taken.
  task automatic send_tick(logic [SB-1:0] s, bit rs, output bit emit, output avg_result_t res);
    int unsigned gap;
    gap = steady ? 0 : pause_len();
    @(negedge clk);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.sample_value <= s;
    in_bus.restart_window <= rs;
    do @(posedge clk); while (!in_bus.ready);
    advance_window(s, rs, emit, res);
  endtask

  task automatic settle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IXB-1:0] idx, logic [DB-1:0] d);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= d;
    do @(posedge clk); while (!cfg_bus.ready);
    apply_reg(idx, d);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_bus.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_bus.ready <= 1'b1;
      if (!steady && $urandom_range(0, 99) < 25) stall_left = pause_len();
    end
  end

  always @(posedge clk) begin : check_averages
    avg_result_t got;
    avg_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.average_value = out_bus.average_value;
      got.samples_averaged = out_bus.samples_averaged;
      averages_seen++;
      if (pending_averages.size() == 0) begin
        note_mismatch($sformatf("expected no average, got %0d over %0d samples",
                                got.average_value, got.samples_averaged));
      end else begin
        want = pending_averages.pop_front();
        if (got.average_value !== want.average_value)
          note_mismatch($sformatf("average_value expected %0d got %0d",
                                  want.average_value, got.average_value));
        if (got.samples_averaged !== want.samples_averaged)
          note_mismatch($sformatf("samples_averaged expected %0d got %0d",
                                  want.samples_averaged, got.samples_averaged));
      end
    end
  end

  initial begin
    bit             emit;
    avg_result_t    res;
    plan_row_t      row;
    int unsigned    random_ticks;
    int unsigned    phase_len;
    int unsigned    restart_pct;
    int unsigned    r;
    logic [DB-1:0]  d;

    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.sample_value = '0;
    in_bus.restart_window = 1'b0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    mismatches = 0;
    averages_seen = 0;
    cycles = 0;
    stall_left = 0;
    steady = 1'b0;
    random_ticks = 0;

    sample_ivl = isa_pkg::SAMPLE_IVL_RESET;
    send_ivl = isa_pkg::SEND_IVL_RESET;
    ticks_since_sample = '0;
    ticks_since_send = '0;
    window_sum = '0;
    window_count = '0;

    // Reset intervals: nothing can be due in the first ticks.
    plan.push_back(tick_row(12'hFFF, 1'b0, CHK_NONE, '0, '0));
    plan.push_back(tick_row(12'h000, 1'b1, CHK_NONE, '0, '0));
    // Unknown register indexes are ignored.
    plan.push_back(cfg_row(8'd2, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(8'd255, 32'h0000_0000));
    // Zero sample interval and a one-tick send interval: every tick averages itself.
    plan.push_back(cfg_row(isa_pkg::REG_SAMPLE_INTERVAL, 32'd0));
    plan.push_back(cfg_row(isa_pkg::REG_SEND_INTERVAL, 32'd1));
    plan.push_back(tick_row(12'hFFF, 1'b0, CHK_GIVEN, 12'd4095, 10'd1));
    plan.push_back(tick_row(12'h000, 1'b0, CHK_GIVEN, 12'd0, 10'd1));
    // Two-sample window with truncation.
    plan.push_back(cfg_row(isa_pkg::REG_SEND_INTERVAL, 32'd2));
    plan.push_back(tick_row(12'd4095, 1'b0, CHK_NONE, '0, '0));
    plan.push_back(tick_row(12'd4094, 1'b0, CHK_GIVEN, 12'd4094, 10'd2));
    // A restart throws away the held sample and restarts the send timer.
    plan.push_back(tick_row(12'd100, 1'b0, CHK_NONE, '0, '0));
    plan.push_back(tick_row(12'd7, 1'b1, CHK_NONE, '0, '0));
    plan.push_back(tick_row(12'd9, 1'b0, CHK_GIVEN, 12'd8, 10'd2));
    // Zero send interval.
    plan.push_back(cfg_row(isa_pkg::REG_SEND_INTERVAL, 32'd0));
    plan.push_back(tick_row(12'd1234, 1'b0, CHK_GIVEN, 12'd1234, 10'd1));
    // Empty window: the send time passes while no sample is held.
    plan.push_back(cfg_row(isa_pkg::REG_SAMPLE_INTERVAL, 32'd3));
    plan.push_back(tick_row(12'd2048, 1'b0, CHK_MODEL, '0, '0));
    plan.push_back(tick_row(12'd1, 1'b0, CHK_MODEL, '0, '0));
    plan.push_back(tick_row(12'd2730, 1'b0, CHK_MODEL, '0, '0));
    plan.push_back(tick_row(12'd1365, 1'b0, CHK_MODEL, '0, '0));
    // Largest intervals, with bits above the register width set.
    plan.push_back(cfg_row(isa_pkg::REG_SAMPLE_INTERVAL, 32'hA5A5_FFFF));
    plan.push_back(cfg_row(isa_pkg::REG_SEND_INTERVAL, 32'h5A5F_FFFF));
    plan.push_back(tick_row(12'hFFF, 1'b0, CHK_MODEL, '0, '0));
    plan.push_back(tick_row(12'h000, 1'b1, CHK_MODEL, '0, '0));
    // Restart on a tick that also takes a sample and sends.
    plan.push_back(cfg_row(isa_pkg::REG_SAMPLE_INTERVAL, 32'd1));
    plan.push_back(cfg_row(isa_pkg::REG_SEND_INTERVAL, 32'd1));
    plan.push_back(tick_row(12'd5, 1'b1, CHK_MODEL, '0, '0));
    plan.push_back(tick_row(12'hFFF, 1'b1, CHK_MODEL, '0, '0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_CFG) begin
        settle();
        write_reg(row.index, row.data);
      end else begin
        send_tick(row.sample, row.restart, emit, res);
        if (row.chk == CHK_GIVEN) pending_averages.push_back(row.given);
        else if (row.chk == CHK_MODEL && emit) pending_averages.push_back(res);
      end
    end

    // Long window that fills the sample count and then drops the extra samples.
    settle();
    write_reg(isa_pkg::REG_SAMPLE_INTERVAL, 32'd0);
    write_reg(isa_pkg::REG_SEND_INTERVAL, 32'd1030);
    for (int unsigned k = 0; k < 1040; k++) begin
      send_tick(SB'($urandom_range(3000, 4095)), k == 0, emit, res);
      if (emit) pending_averages.push_back(res);
    end

    while (random_ticks < 740) begin
      settle();
      r = $urandom_range(0, 99);
      if (r < 60) d = $urandom_range(0, 4);
      else if (r < 80) d = $urandom_range(5, 12);
      else if (r < 93) d = $urandom_range(1000, 60000);
      else d = 32'h0000_FFFF;
      if ($urandom_range(0, 1) != 0) d[DB-1:SIB] = SI_HI'($urandom());
      if ($urandom_range(0, 99) < 85) write_reg(isa_pkg::REG_SAMPLE_INTERVAL, d);
      r = $urandom_range(0, 99);
      if (r < 60) d = $urandom_range(0, 20);
      else if (r < 85) d = $urandom_range(21, 80);
      else if (r < 93) d = $urandom_range(10000, 600000);
      else d = 32'h000F_FFFF;
      if ($urandom_range(0, 1) != 0) d[DB-1:SDB] = SD_HI'($urandom());
      if ($urandom_range(0, 99) < 85) write_reg(isa_pkg::REG_SEND_INTERVAL, d);
      if ($urandom_range(0, 9) == 0) write_reg(IXB'($urandom_range(2, 255)), $urandom());

      steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 2);
      restart_pct = (r == 0) ? 0 : (r == 1) ? 3 : 15;
      phase_len = $urandom_range(20, 80);
      for (int unsigned k = 0; k < phase_len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 10) d = '1;
        else if (r < 20) d = '0;
        else d = $urandom();
        send_tick(SB'(d), $urandom_range(0, 99) < restart_pct, emit, res);
        if (emit) pending_averages.push_back(res);
        random_ticks++;
      end
    end

    steady = 1'b0;
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_averages.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[interval_sample_averager_core.f]
hdl/isa_pkg.sv
hdl/isa_if.sv
hdl/interval_sample_averager_core.sv
verif/tb_interval_sample_averager_core.sv
